>>> src/bfcm_pkg.sv
package bfcm_pkg;

    // Planes tested, capped by the six plane registers and six mask bits
    localparam int NUM_PLANES  = 6;
    localparam int REG_COUNT   = 6;
    localparam int PLANE_LIMIT = (NUM_PLANES < REG_COUNT) ? NUM_PLANES : REG_COUNT;

    localparam int COORD_W = 16;
    localparam int PROD_W  = 2 * COORD_W;
    // three products and the scaled offset stay below 2^33 in magnitude
    localparam int SUM_W   = PROD_W + 2;
    localparam int D_SHIFT = 14;
    localparam int PLANE_W = 4 * COORD_W;
    localparam int MASK_W  = REG_COUNT;
    localparam int IDX_W   = $clog2(REG_COUNT);

    localparam logic [MASK_W-1:0] LIMIT_MASK = MASK_W'((1 << PLANE_LIMIT) - 1);

    localparam int IN_FIELDS_W = 6 * COORD_W + MASK_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 + MASK_W;
    localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        CLASS_OUTSIDE   = 2'd0,
        CLASS_INTERSECT = 2'd1,
        CLASS_INSIDE    = 2'd2
    } box_class_t;

    // per axis: the larger and the smaller of the two given coordinates
    typedef struct packed {
        coord_t [2:0] big;
        coord_t [2:0] little;
    } extent_t;

    // any_pass: the best corner is strictly in front of the plane
    // all_pass: the worst corner is strictly in front of the plane
    typedef struct packed {
        logic any_pass;
        logic all_pass;
    } plane_stat_t;

endpackage

>>> src/bfcm_plane_eval.sv
module bfcm_plane_eval
    import bfcm_pkg::*;
(
    input  logic [PLANE_W-1:0] plane,
    input  extent_t            ext,
    output plane_stat_t        stat
);

    // For each axis the extreme corner terms come from one multiply each:
    // a*max over {lo,hi} picks the larger coordinate when a >= 0, the smaller otherwise.
    always_comb
    begin
        logic signed [COORD_W-1:0] coef;
        logic signed [COORD_W-1:0] x_top;
        logic signed [COORD_W-1:0] x_bot;
        logic signed [PROD_W-1:0]  p_top;
        logic signed [PROD_W-1:0]  p_bot;
        logic signed [SUM_W-1:0]   sum_top;
        logic signed [SUM_W-1:0]   sum_bot;
        logic signed [SUM_W-1:0]   d_term;

        d_term = $signed({{(SUM_W-COORD_W-D_SHIFT){plane[PLANE_W-1]}},
                          plane[PLANE_W-1 -: COORD_W], {D_SHIFT{1'b0}}});
        sum_top = d_term;
        sum_bot = d_term;
        for (int k = 0; k < 3; k++)
        begin
            coef  = $signed(plane[k*COORD_W +: COORD_W]);
            x_top = coef[COORD_W-1] ? $signed(ext.little[k]) : $signed(ext.big[k]);
            x_bot = coef[COORD_W-1] ? $signed(ext.big[k]) : $signed(ext.little[k]);
            p_top = coef * x_top;
            p_bot = coef * x_bot;
            sum_top = sum_top + SUM_W'(p_top);
            sum_bot = sum_bot + SUM_W'(p_bot);
        end
        stat.any_pass = (sum_top > 0);
        stat.all_pass = (sum_bot > 0);
    end

endmodule

>>> src/bfcm_combine.sv
module bfcm_combine
    import bfcm_pkg::*;
(
    input  plane_stat_t [REG_COUNT-1:0] stat,
    input  logic [MASK_W-1:0]           mask_in,
    output box_class_t                  box_class,
    output logic [MASK_W-1:0]           mask_out
);

    // Walk the planes in order; the first unmasked plane with no passing
    // corner ends the walk, so later planes leave the mask alone.
    always_comb
    begin
        logic stopped;
        logic all_in;

        stopped  = 1'b0;
        all_in   = 1'b1;
        mask_out = mask_in;
        for (int p = 0; p < REG_COUNT; p++)
        begin
            if (p < PLANE_LIMIT && !stopped && !mask_in[p])
            begin
                if (!stat[p].any_pass)
                    stopped = 1'b1;
                else if (stat[p].all_pass)
                    mask_out[p] = 1'b1;
                else
                    all_in = 1'b0;
            end
        end
        if (stopped)
            box_class = CLASS_OUTSIDE;
        else if (all_in)
            box_class = CLASS_INSIDE;
        else
            box_class = CLASS_INTERSECT;
    end

endmodule

>>> src/box_frustum_classify_masked_top.sv
// Box against frustum classifier with a plane skip mask. Each input word
// carries an axis-aligned box (min and max corners, signed Q12.4) and a mask
// of planes already known to pass; the result word gives outside,
// intersecting or inside plus the mask with every plane newly found to hold
// all eight corners added. On the first unmasked plane that no corner passes
// the box is outside and the mask carries only the bits set before it. The
// six planes are loaded through cfg_we/cfg_index/cfg_data (a,b,c Q1.14 and d
// Q12.4, a in the low bits); writes to indexes 6 and 7 are dropped, and the
// planes must only be changed while no box is in flight. Planes reset to
// zero, which no corner passes, so load them before use. Throughput is one
// box per clock while the result side accepts; a box passes through the input
// register and then the result register, with the six plane units working
// in parallel between them. Backpressure on the result side stalls both
// stages, and a new box is still taken while a finished result is waiting
// provided the input register is free.
module box_frustum_classify_masked_top
    import bfcm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // min x, min y, min z, max x, max y, max z, skip_mask_in, zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // box_class, skip_mask_out
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [PLANE_W-1:0]    cfg_data
);

    logic [PLANE_W-1:0] plane_reg [REG_COUNT];

    // input stage
    logic                s1_valid_reg;
    coord_t [5:0]        s1_coord_reg;
    logic [MASK_W-1:0]   s1_mask_reg;

    // result stage
    logic                res_valid_reg;
    box_class_t          res_class_reg;
    logic [MASK_W-1:0]   res_mask_reg;

    logic                advance;
    logic                take;
    extent_t             ext;
    plane_stat_t [REG_COUNT-1:0] stat;
    box_class_t          class_next;
    logic [MASK_W-1:0]   mask_next;

    assign advance  = !res_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    // plane registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                plane_reg[i] <= '0;
        end
        else if (cfg_we && cfg_index < IDX_W'(REG_COUNT))
        begin
            plane_reg[cfg_index] <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < 6; i++)
                s1_coord_reg[i] <= s_tdata[i*COORD_W +: COORD_W];
            s1_mask_reg <= s_tdata[6*COORD_W +: MASK_W];
        end
    end

    // order each axis so the plane units know which value is larger;
    // an inverted box still gives the same pair of coordinates
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if ($signed(s1_coord_reg[k]) > $signed(s1_coord_reg[k+3]))
            begin
                ext.big[k]    = s1_coord_reg[k];
                ext.little[k] = s1_coord_reg[k+3];
            end
            else
            begin
                ext.big[k]    = s1_coord_reg[k+3];
                ext.little[k] = s1_coord_reg[k];
            end
        end
    end

    for (genvar p = 0; p < REG_COUNT; p++)
    begin : g_plane
        bfcm_plane_eval u_eval (
            .plane (plane_reg[p]),
            .ext   (ext),
            .stat  (stat[p])
        );
    end

    bfcm_combine u_combine (
        .stat      (stat),
        .mask_in   (s1_mask_reg),
        .box_class (class_next),
        .mask_out  (mask_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            res_class_reg <= class_next;
            res_mask_reg  <= mask_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = OUT_DATA_W'({res_mask_reg, res_class_reg});

`ifndef SYNTHESIS
    // inside means every tested plane ends up in the mask
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_class_reg == CLASS_INSIDE
        |-> (res_mask_reg & LIMIT_MASK) == LIMIT_MASK)
        else $error("inside result with a tested plane missing from the mask");

    // outside means the failing plane can never be in the mask
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_class_reg == CLASS_OUTSIDE
        |-> (res_mask_reg & LIMIT_MASK) != LIMIT_MASK)
        else $error("outside result with a full plane mask");

    // the mask only ever gains bits
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (mask_next & s1_mask_reg) == s1_mask_reg)
        else $error("mask lost an input bit");

    // a stalled box holds in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance
        |=> s1_valid_reg && $stable(s1_coord_reg) && $stable(s1_mask_reg))
        else $error("input register changed while stalled");
`endif

endmodule

>>> sim/box_frustum_classify_masked_top_test.sv
`timescale 1ns / 1ps

module box_frustum_classify_masked_top_test;

    import bfcm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    // two-stage pipe, plus a little margin
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_REPORTED   = 10;
    localparam int CORNERS        = 8;
    // 1.0 in Q1.14
    localparam int UNIT_NORMAL    = 16384;
    localparam logic [MASK_W-1:0] SKIP_NONE = '0;
    localparam logic [MASK_W-1:0] SKIP_ALL  = '1;

    // plane registers; the last two indexes are decoded but unused
    typedef enum logic [IDX_W-1:0] {
        REG_PLANE_0,
        REG_PLANE_1,
        REG_PLANE_2,
        REG_PLANE_3,
        REG_PLANE_4,
        REG_PLANE_5,
        REG_SPARE_6,
        REG_SPARE_7
    } reg_index_t;

    // input word layout, lowest bits first: lo x,y,z, hi x,y,z, skip
    typedef struct packed {
        logic [MASK_W-1:0] skip;
        coord_t [2:0]      hi;
        coord_t [2:0]      lo;
    } box_t;

    typedef struct packed {
        logic [MASK_W-1:0] skip;
        box_class_t        cls;
    } verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // min x, min y, min z, max x, max y, max z, skip_mask_in, zero fill
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // box_class, skip_mask_out
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [IDX_W-1:0]      cfg_index = '0;
    logic [PLANE_W-1:0]    cfg_data = '0;

    // local copy of the plane registers
    logic [PLANE_W-1:0] plane_regs [REG_COUNT];
    verdict_t           verdicts_due[$];
    bit                 idle_on = 1'b0;
    int                 mismatches = 0;
    int                 results_seen = 0;
    int                 quiet_cycles = 0;
    int                 stall_left = 0;

    // frustum currently loaded by load_frustum, used to aim the boxes
    int                 frustum_centre [3];
    int                 frustum_half;

    box_frustum_classify_masked_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: every unmasked plane below the limit is tried on all
    // eight corners. Strictly positive counts as a pass; a plane with no
    // passing corner ends the test as outside with the mask built so far.
    // ------------------------------------------------------------------
    function automatic verdict_t classify_box(box_t box);
        verdict_t v;
        longint   a, b, c, d, x, y, z;
        int       passing;
        bit       whole = 1'b1;
        v.skip = box.skip;
        v.cls  = CLASS_INSIDE;
        for (int p = 0; p < PLANE_LIMIT; p++)
        begin
            if (v.skip[p])
                continue;
            a = $signed(plane_regs[p][0 +: COORD_W]);
            b = $signed(plane_regs[p][COORD_W +: COORD_W]);
            c = $signed(plane_regs[p][2*COORD_W +: COORD_W]);
            d = $signed(plane_regs[p][3*COORD_W +: COORD_W]);
            d = d <<< D_SHIFT;
            passing = 0;
            for (int k = 0; k < CORNERS; k++)
            begin
                x = k[0] ? $signed(box.hi[0]) : $signed(box.lo[0]);
                y = k[1] ? $signed(box.hi[1]) : $signed(box.lo[1]);
                z = k[2] ? $signed(box.hi[2]) : $signed(box.lo[2]);
                if (a * x + b * y + c * z + d > 0)
                    passing++;
            end
            if (passing == 0)
            begin
                v.cls = CLASS_OUTSIDE;
                return v;
            end
            if (passing == CORNERS)
                v.skip[p] = 1'b1;
            else
                whole = 1'b0;
        end
        v.cls = whole ? CLASS_INSIDE : CLASS_INTERSECT;
        return v;
    endfunction

    function automatic logic [PLANE_W-1:0] pack_plane(int a, int b, int c, int d);
        return {d[COORD_W-1:0], c[COORD_W-1:0], b[COORD_W-1:0], a[COORD_W-1:0]};
    endfunction

    function automatic coord_t clamp_coord(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return coord_t'(v);
    endfunction

    function automatic box_t make_box(int x0, int y0, int z0, int x1, int y1, int z1,
                                      logic [MASK_W-1:0] skip);
        box_t box;
        box.lo   = {clamp_coord(z0), clamp_coord(y0), clamp_coord(x0)};
        box.hi   = {clamp_coord(z1), clamp_coord(y1), clamp_coord(x1)};
        box.skip = skip;
        return box;
    endfunction

    function automatic logic [MASK_W-1:0] random_skip();
        return ($urandom_range(0, 9) < 7) ? SKIP_NONE : MASK_W'($urandom_range(0, 63));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus side. Inputs move on the falling edge; a word counts as
    // taken at the rising edge where tvalid and tready are both high.
    // ------------------------------------------------------------------
    task automatic send_box(box_t box);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = IN_DATA_W'(box);
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        verdicts_due.insert(verdicts_due.size(), classify_box(box));
    endtask

    // drop tvalid, then let the pipe empty before touching the planes
    task automatic drain_pipe();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_plane(reg_index_t idx, logic [PLANE_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        if (idx < REG_COUNT)
            plane_regs[idx] = value;
    endtask

    // Axis slabs around a centre: even planes bound from below, odd ones
    // from above. tilt adds noise to the normals so the planes lean.
    task automatic load_frustum(int cx, int cy, int cz, int half, int tilt);
        int n [3];
        int centre [3];
        int sgn;
        centre = '{cx, cy, cz};
        frustum_centre = centre;
        frustum_half   = half;
        for (int p = 0; p < REG_COUNT; p++)
        begin
            sgn = (p % 2 == 0) ? 1 : -1;
            for (int k = 0; k < 3; k++)
                n[k] = int'($urandom_range(0, 2 * tilt)) - tilt;
            n[p / 2] += sgn * UNIT_NORMAL;
            write_plane(reg_index_t'(p),
                        pack_plane(n[0], n[1], n[2], -sgn * centre[p / 2] + half));
        end
    endtask

    // box somewhere around the loaded frustum, mostly small, sometimes
    // inverted on an axis
    function automatic box_t box_near_frustum();
        int lo [3];
        int hi [3];
        int mid, size, reach, t;
        reach = frustum_half + 3000;
        for (int k = 0; k < 3; k++)
        begin
            mid  = frustum_centre[k] + int'($urandom_range(0, 2 * reach)) - reach;
            size = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4000)
                                               : $urandom_range(0, 800);
            lo[k] = mid - size;
            hi[k] = mid + size;
            if ($urandom_range(0, 15) == 0)
            begin
                t = lo[k];
                lo[k] = hi[k];
                hi[k] = t;
            end
        end
        return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], random_skip());
    endfunction

    function automatic box_t box_anywhere();
        box_t box;
        box.lo   = {coord_t'($urandom), coord_t'($urandom), coord_t'($urandom)};
        box.hi   = {coord_t'($urandom), coord_t'($urandom), coord_t'($urandom)};
        box.skip = random_skip();
        return box;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall bursts while idling is on.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 13);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= MAX_REPORTED)
            $display("word %0d: %s expected %0d got %0d", results_seen, what, want, got);
    endtask

    // each result word against the oldest outstanding verdict
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdicts_due.size() == 0)
            begin
                report_mismatch("unexpected result, class", -1, m_tdata[1:0]);
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (m_tdata[1:0] !== want.cls)
                    report_mismatch("box_class", want.cls, m_tdata[1:0]);
                if (m_tdata[2 +: MASK_W] !== want.skip)
                    report_mismatch("skip_mask_out", want.skip, m_tdata[2 +: MASK_W]);
            end
            results_seen++;
        end
    end

    // give up if nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // planes straight out of reset are all zero: nothing passes them
    task automatic test_reset_planes();
        send_box(make_box(-100, -100, -100, 100, 100, 100, SKIP_NONE));
        send_box(make_box(-100, -100, -100, 100, 100, 100, SKIP_ALL));
        send_box(make_box(0, 0, 0, 0, 0, 0, MASK_W'(6'b010101)));
        drain_pipe();
    endtask

    // writes to the unused indexes must leave the planes alone
    task automatic test_spare_index();
        write_plane(REG_SPARE_6, '1);
        write_plane(REG_SPARE_7, pack_plane(UNIT_NORMAL, 0, 0, 100));
        send_box(make_box(-100, -100, -100, 100, 100, 100, SKIP_NONE));
        drain_pipe();
    endtask

    // cube of half size 100.0 around the origin, straight planes
    task automatic test_directed_frustum();
        load_frustum(0, 0, 0, 1600, 0);
        // wholly inside, straddling plane 0, outside on plane 0
        send_box(make_box(-100, -100, -100, 100, 100, 100, SKIP_NONE));
        send_box(make_box(-2000, -100, -100, 0, 100, 100, SKIP_NONE));
        send_box(make_box(-5000, -100, -100, -3000, 100, 100, SKIP_NONE));
        // outside only on the last plane: earlier bits already set
        send_box(make_box(-100, -100, 2000, 100, 100, 3000, SKIP_NONE));
        send_box(make_box(-100, -100, 2000, 100, 100, 3000, MASK_W'(6'b100000)));
        // every plane skipped: mask passes straight through
        send_box(make_box(-5000, -5000, -5000, -3000, -3000, -3000, SKIP_ALL));
        // inverted corners, inside and straddling
        send_box(make_box(100, 100, 100, -100, -100, -100, SKIP_NONE));
        send_box(make_box(2000, 100, 100, -100, -100, -100, SKIP_NONE));
        // coordinate extremes
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767, SKIP_NONE));
        send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767, SKIP_NONE));
        send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768, SKIP_NONE));
        // a point exactly on plane 0 does not pass; one step in does
        send_box(make_box(-1600, 0, 0, -1600, 0, 0, SKIP_NONE));
        send_box(make_box(-1599, 0, 0, -1599, 0, 0, SKIP_NONE));
        send_box(make_box(-2000, 0, 0, 0, 0, 0, MASK_W'(6'b001110)));
        drain_pipe();
    endtask

    // most negative and most positive plane fields
    task automatic test_extreme_planes();
        write_plane(REG_PLANE_0, pack_plane(-32768, 32767, -32768, 32767));
        write_plane(REG_PLANE_1, pack_plane(32767, -32768, 32767, -32768));
        write_plane(REG_PLANE_2, '1);
        write_plane(REG_PLANE_3, pack_plane(32767, 32767, 32767, 32767));
        send_box(make_box(-32768, 32767, -32768, -32768, 32767, -32768, MASK_W'(6'b111100)));
        send_box(make_box(32767, -32768, 32767, 32767, -32768, 32767, MASK_W'(6'b111100)));
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767, MASK_W'(6'b110000)));
        send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768, MASK_W'(6'b110011)));
        send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767, MASK_W'(6'b110000)));
        drain_pipe();
    endtask

    task automatic test_random_frustum();
        int half, tilt;
        for (int s = 0; s < 5; s++)
        begin
            half = $urandom_range(800, 6000);
            tilt = (s == 0) ? 0 : $urandom_range(0, 3000);
            load_frustum(int'($urandom_range(0, 16000)) - 8000,
                         int'($urandom_range(0, 16000)) - 8000,
                         int'($urandom_range(0, 16000)) - 8000, half, tilt);
            for (int i = 0; i < 200; i++)
                send_box(box_near_frustum());
            drain_pipe();
        end
    endtask

    // planes drawn at random, including zero and all ones; boxes anywhere
    task automatic test_random_planes();
        logic [PLANE_W-1:0] value;
        for (int s = 0; s < 3; s++)
        begin
            for (int p = 0; p < REG_COUNT; p++)
            begin
                case ((s == 2) ? 1 : $urandom_range(0, 5))
                    0:       value = '0;
                    1:       value = '1;
                    default: value = {$urandom, $urandom};
                endcase
                write_plane(reg_index_t'(p), value);
            end
            for (int i = 0; i < 100; i++)
                send_box(box_anywhere());
            drain_pipe();
        end
    endtask

    // back to back words with no stalls on either side
    task automatic test_streaming();
        idle_on = 1'b0;
        load_frustum(0, 0, 0, 3000, 1500);
        for (int i = 0; i < 250; i++)
            send_box(box_near_frustum());
        drain_pipe();
    endtask

    initial
    begin
        for (int p = 0; p < REG_COUNT; p++)
            plane_regs[p] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        idle_on = 1'b1;
        test_reset_planes();
        test_spare_index();
        test_directed_frustum();
        test_extreme_planes();
        test_random_frustum();
        test_random_planes();
        test_streaming();

        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
src/bfcm_pkg.sv
src/bfcm_plane_eval.sv
src/bfcm_combine.sv
src/box_frustum_classify_masked_top.sv
sim/box_frustum_classify_masked_top_test.sv
